@@ rtl/edk_pkg.sv @@
// Shared constants and types for the exponential distance kernel weight block.
`default_nettype none
package edk_pkg;

	// Grid defaults and field widths.
	localparam int unsigned GRID_X_CELLS_DEF = 256;
	localparam int unsigned GRID_Y_CELLS_DEF = 256;
	localparam int unsigned IDX_W    = 8;
	localparam int unsigned REG_W    = 24;
	localparam int unsigned WEIGHT_W = 17;
	localparam int unsigned CFG_IDX_W = 2;

	// Datapath widths.
	localparam int unsigned DIST_W = 32;          // |diff| * cell size, Q.16
	localparam int unsigned SQ_W   = 62;          // (dist * dist) / 4
	localparam int unsigned RAD_W  = 63;          // radicand
	localparam int unsigned ROOT_W = 32;          // half distance, Q.16
	localparam int unsigned HP_W   = ROOT_W + REG_W;
	localparam int unsigned A_W    = HP_W - 15;   // exponent, Q.16
	localparam int unsigned ALO_W  = 20;          // exponent below the limit
	localparam int unsigned N_W    = 5;
	localparam int unsigned R30_W  = 30;
	localparam int unsigned TERM_W = 31;
	localparam int unsigned SUM_W  = 33;

	// Exponential evaluation constants.
	localparam int unsigned LN2_Q16      = 45426;
	localparam int unsigned N_MAX        = 17;
	localparam int unsigned EXP_LIMIT    = 12 * 65536;
	localparam int unsigned TAYLOR_TERMS = 12;
	localparam int unsigned ONE_Q30      = 1 << 30;
	localparam int unsigned RND_BASE     = 13;

	// Register reset values.
	localparam logic [REG_W-1:0] CELL_WIDTH_RST  = 24'd65536;
	localparam logic [REG_W-1:0] CELL_HEIGHT_RST = 24'd65536;
	localparam logic [REG_W-1:0] DECAY_SCALE_RST = 24'd16384;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CELL_WIDTH  = 2'd0,
		REG_CELL_HEIGHT = 2'd1,
		REG_DECAY_SCALE = 2'd2
	} edk_reg_t;

	// Side information that travels with the series evaluation.
	typedef struct packed {
		logic             zero;
		logic [N_W-1:0]   n;
		logic [R30_W-1:0] r30;
	} edk_exp_ctl_t;

endpackage
`default_nettype wire

@@ rtl/exp_distance_kernel_weight_top.sv @@
// Top level of the exponential distance kernel weight pipeline.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  row_x, row_y, col_x, col_y
//  m_axis    out  m_axis_tvalid/m_axis_tready  weight (Q1.16)
//  cfg       in   cfg_we                       cfg_index, cfg_wdata
//
// One beat is accepted per cycle while s_axis_tready is high. A beat passes the
// input stages, the 32 square root stages, the exponent stages, the twelve series
// terms of three stages each, the final stage and the output register.
// All stages share one enable, so a stall freezes the whole pipeline in place.
// An output register with a skid stage lets the pipeline keep accepting
// beats while one finished weight waits; s_axis_tready drops once both hold one.
// Reset clears valid bits and loads the configuration reset values.
`default_nettype none
module exp_distance_kernel_weight_top #(
	parameter int unsigned GRID_X_CELLS = edk_pkg::GRID_X_CELLS_DEF,
	parameter int unsigned GRID_Y_CELLS = edk_pkg::GRID_Y_CELLS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [31:0]                     s_axis_tdata,  // row_x, row_y, col_x, col_y
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [23:0]                     m_axis_tdata,  // weight, zero padding
	input  logic                            cfg_we,
	input  logic [edk_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [edk_pkg::REG_W-1:0]       cfg_wdata
);
	import edk_pkg::*;

	// Configuration registers.
	logic [REG_W-1:0] cell_width_q, cell_height_q, decay_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_width_q  <= CELL_WIDTH_RST;
			cell_height_q <= CELL_HEIGHT_RST;
			decay_scale_q <= DECAY_SCALE_RST;
		end else if (cfg_we) begin
			case (edk_reg_t'(cfg_index))
				REG_CELL_WIDTH:  cell_width_q  <= cfg_wdata;
				REG_CELL_HEIGHT: cell_height_q <= cfg_wdata;
				REG_DECAY_SCALE: decay_scale_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The pipeline advances whenever the skid stage is empty.
	logic en;
	logic skid_vld_q;
	logic out_vld_q;
	logic accept;

	assign en            = !skid_vld_q;
	assign s_axis_tready = en;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Stage 1: index differences scaled by the cell size; grid bound check.
	logic [IDX_W-1:0] row_x, row_y, col_x, col_y;
	logic [IDX_W-1:0] diff_x, diff_y;
	logic             oob;

	assign row_x  = s_axis_tdata[7:0];
	assign row_y  = s_axis_tdata[15:8];
	assign col_x  = s_axis_tdata[23:16];
	assign col_y  = s_axis_tdata[31:24];
	assign diff_x = (row_x > col_x) ? row_x - col_x : col_x - row_x;
	assign diff_y = (row_y > col_y) ? row_y - col_y : col_y - row_y;
	assign oob    = (32'(row_x) >= GRID_X_CELLS) || (32'(col_x) >= GRID_X_CELLS) ||
	                (32'(row_y) >= GRID_Y_CELLS) || (32'(col_y) >= GRID_Y_CELLS);

	logic              vld_s1, vld_s2, vld_s3;
	logic [DIST_W-1:0] dx_s1, dy_s1;
	logic              oob_s1, oob_s2, oob_s3;
	logic [SQ_W-1:0]   sqx_s2, sqy_s2;
	logic [RAD_W-1:0]  rad_s3;
	logic [63:0]       sq_x, sq_y;

	assign sq_x = 64'(dx_s1) * 64'(dx_s1);
	assign sq_y = 64'(dy_s1) * 64'(dy_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= DIST_W'(diff_x) * DIST_W'(cell_width_q);
			dy_s1  <= DIST_W'(diff_y) * DIST_W'(cell_height_q);
			oob_s1 <= oob;
			// Stage 2: squared distances, each divided by four.
			sqx_s2 <= sq_x[63:2];
			sqy_s2 <= sq_y[63:2];
			oob_s2 <= oob_s1;
			// Stage 3: radicand.
			rad_s3 <= RAD_W'(sqx_s2) + RAD_W'(sqy_s2);
			oob_s3 <= oob_s2;
		end
	end

	// Square root of the radicand gives half the Euclidean distance.
	logic              sq_vld;
	logic [ROOT_W-1:0] root;
	logic              sq_oob;

	edk_isqrt #(
		.TAG_W (1)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.in_rad    (rad_s3),
		.in_tag    (oob_s3),
		.out_valid (sq_vld),
		.out_root  (root),
		.out_tag   (sq_oob)
	);

	// Stage 4: half distance times decay scale. Stage 5: exponent and range.
	// Stage 6: split the exponent into a power of two and a remainder.
	logic              vld_s4, vld_s5, vld_s6;
	logic [HP_W-1:0]   hp_s4;
	logic              oob_s4;
	logic [A_W-1:0]    a_full;
	logic [ALO_W-1:0]  a_s5;
	logic              zero_s5;
	logic [N_MAX:1]    ge_vec;
	logic [N_W-1:0]    n_cnt;
	logic [ALO_W-1:0]  r_val;
	edk_exp_ctl_t      ctl_s6;

	assign a_full = hp_s4[HP_W-1:15];

	always_comb begin
		for (int j = 1; j <= N_MAX; j++) begin
			ge_vec[j] = a_s5 >= ALO_W'(j * LN2_Q16);
		end
	end

	assign n_cnt = N_W'($countones(ge_vec));
	assign r_val = a_s5 - ALO_W'(n_cnt) * ALO_W'(LN2_Q16);

	always_ff @(posedge clk) begin
		if (en) begin
			hp_s4      <= HP_W'(root) * HP_W'(decay_scale_q);
			oob_s4     <= sq_oob;
			a_s5       <= a_full[ALO_W-1:0];
			zero_s5    <= oob_s4 || (a_full >= A_W'(EXP_LIMIT));
			ctl_s6.zero <= zero_s5;
			ctl_s6.n    <= n_cnt;
			ctl_s6.r30  <= {r_val[15:0], 14'd0};
		end
	end

	// Twelve series terms, each three stages deep.
	logic                    vld_c  [TAYLOR_TERMS];
	logic [TERM_W-1:0]       term_c [TAYLOR_TERMS];
	logic signed [SUM_W-1:0] sum_c  [TAYLOR_TERMS];
	edk_exp_ctl_t            ctl_c  [TAYLOR_TERMS];

	for (genvar k = 0; k < TAYLOR_TERMS; k++) begin : g_term
		logic                    vld_in;
		logic [TERM_W-1:0]       term_in;
		logic signed [SUM_W-1:0] sum_in;
		edk_exp_ctl_t            ctl_in;

		if (k == 0) begin : g_first
			assign vld_in  = vld_s6;
			assign term_in = TERM_W'(ONE_Q30);
			assign sum_in  = signed'(SUM_W'(ONE_Q30));
			assign ctl_in  = ctl_s6;
		end else begin : g_next
			assign vld_in  = vld_c[k-1];
			assign term_in = term_c[k-1];
			assign sum_in  = sum_c[k-1];
			assign ctl_in  = ctl_c[k-1];
		end

		edk_term #(
			.K (k + 1)
		) u_term (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (vld_in),
			.in_term   (term_in),
			.in_sum    (sum_in),
			.in_ctl    (ctl_in),
			.out_valid (vld_c[k]),
			.out_term  (term_c[k]),
			.out_sum   (sum_c[k]),
			.out_ctl   (ctl_c[k])
		);
	end

	// Final stage: round and scale the series sum by 2^-n, force zero if needed.
	// The last term value itself is not needed past the chain.
	edk_exp_ctl_t      ctl_last;
	logic [31:0]       sum_u;
	logic [N_W-1:0]    sh_rnd;
	logic [31:0]       rnd;
	logic [31:0]       w_shift;
	logic              vld_fin;
	logic [WEIGHT_W-1:0] wt_fin;
	logic              term_unused;

	assign ctl_last    = ctl_c[TAYLOR_TERMS-1];
	assign term_unused = ^term_c[TAYLOR_TERMS-1];
	assign sum_u       = sum_c[TAYLOR_TERMS-1][31:0];
	assign sh_rnd      = N_W'(RND_BASE) + ctl_last.n;
	assign rnd         = sum_u + (32'd1 << sh_rnd);
	assign w_shift     = rnd >> (sh_rnd + N_W'(1));

	always_ff @(posedge clk) begin
		if (en) begin
			wt_fin <= (ctl_last.zero || term_unused && 1'b0) ? '0 : w_shift[WEIGHT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_fin <= 1'b0;
		end else if (en) begin
			vld_s1  <= accept;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= sq_vld;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_fin <= vld_c[TAYLOR_TERMS-1];
		end
	end

	// Output register and skid stage. A finished weight lands in the output
	// register, or in the skid stage when the output register is held.
	logic [WEIGHT_W-1:0] out_wt_q, skid_wt_q;
	logic                load_new;
	logic                out_busy;

	assign load_new = en && vld_fin;
	assign out_busy = out_vld_q && !m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (!out_busy) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end
		end else if (load_new) begin
			if (out_busy) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (!out_busy) begin
				out_wt_q <= skid_wt_q;
			end
		end else if (load_new) begin
			if (out_busy) begin
				skid_wt_q <= wt_fin;
			end else begin
				out_wt_q <= wt_fin;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {7'd0, out_wt_q};

`ifndef SYNTHESIS
	// A weight in the skid stage implies one waiting in the output register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid stage holds a weight while the output register is empty");

	// The skid stage only fills behind an occupied output register.
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!out_vld_q |=> !skid_vld_q)
		else $error("skid stage filled with an empty output register");

	// A weight never exceeds 1.0.
	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (out_wt_q <= 17'd65536))
		else $error("weight above 1.0");
`endif

endmodule
`default_nettype wire

@@ rtl/edk_isqrt.sv @@
// Pipelined digit-by-digit integer square root, one result bit per stage.
`default_nettype none
module edk_isqrt #(
	parameter int unsigned TAG_W = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [edk_pkg::RAD_W-1:0]   in_rad,
	input  logic [TAG_W-1:0]            in_tag,
	output logic                        out_valid,
	output logic [edk_pkg::ROOT_W-1:0]  out_root,
	output logic [TAG_W-1:0]            out_tag
);
	import edk_pkg::*;

	localparam int unsigned STEPS = ROOT_W;

	logic [RAD_W-1:0] rad_s [STEPS];
	logic [RAD_W:0]   res_s [STEPS];
	logic [TAG_W-1:0] tag_s [STEPS];
	logic             vld_s [STEPS];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam logic [RAD_W:0] BIT = {{RAD_W{1'b0}}, 1'b1} << (RAD_W - 1 - 2 * i);
		logic [RAD_W-1:0] rad_in;
		logic [RAD_W:0]   res_in;
		logic [TAG_W-1:0] tag_in;
		logic             vld_in;
		logic [RAD_W:0]   trial;
		logic             fits;

		if (i == 0) begin : g_first
			assign rad_in = in_rad;
			assign res_in = '0;
			assign tag_in = in_tag;
			assign vld_in = in_valid;
		end else begin : g_next
			assign rad_in = rad_s[i-1];
			assign res_in = res_s[i-1];
			assign tag_in = tag_s[i-1];
			assign vld_in = vld_s[i-1];
		end

		assign trial = res_in + BIT;
		assign fits  = {1'b0, rad_in} >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				if (fits) begin
					rad_s[i] <= rad_in - trial[RAD_W-1:0];
					res_s[i] <= (res_in >> 1) + BIT;
				end else begin
					rad_s[i] <= rad_in;
					res_s[i] <= res_in >> 1;
				end
				tag_s[i] <= tag_in;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_in;
			end
		end
	end

	assign out_valid = vld_s[STEPS-1];
	assign out_root  = res_s[STEPS-1][ROOT_W-1:0];
	assign out_tag   = tag_s[STEPS-1];

endmodule
`default_nettype wire

@@ rtl/edk_term.sv @@
// One Taylor series term of exp(-r): multiply, divide by K, accumulate.
`default_nettype none
module edk_term #(
	parameter int unsigned K = 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_valid,
	input  logic [edk_pkg::TERM_W-1:0]         in_term,
	input  logic signed [edk_pkg::SUM_W-1:0]   in_sum,
	input  edk_pkg::edk_exp_ctl_t              in_ctl,
	output logic                               out_valid,
	output logic [edk_pkg::TERM_W-1:0]         out_term,
	output logic signed [edk_pkg::SUM_W-1:0]   out_sum,
	output edk_pkg::edk_exp_ctl_t              out_ctl
);
	import edk_pkg::*;

	// Reciprocal of K in Q.32; the estimate is at most one below the quotient.
	localparam logic [32:0] RECIP = 33'((64'd1 << 32) / K);
	localparam bit          ODD   = (K % 2) == 1;

	logic                    vld_s1, vld_s2, vld_s3;
	logic [TERM_W-1:0]       x_s1, x_s2;
	logic [31:0]             q0_s2;
	logic signed [SUM_W-1:0] sum_s1, sum_s2, sum_s3;
	edk_exp_ctl_t            ctl_s1, ctl_s2, ctl_s3;
	logic [TERM_W-1:0]       term_s3;

	logic [TERM_W+R30_W-1:0] prod_a;
	logic [63:0]             prod_b;
	logic [31:0]             qk;
	logic [31:0]             rem;
	logic [31:0]             quo;
	logic signed [SUM_W-1:0] term_ext;

	assign prod_a   = (TERM_W + R30_W)'(in_term) * (TERM_W + R30_W)'(in_ctl.r30);
	assign prod_b   = 64'(x_s1) * 64'(RECIP);
	assign qk       = q0_s2 * 32'(K);
	assign rem      = 32'(x_s2) - qk;
	assign quo      = (rem >= 32'(K)) ? q0_s2 + 32'd1 : q0_s2;
	assign term_ext = signed'(SUM_W'(quo[TERM_W-1:0]));

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= prod_a[TERM_W+R30_W-1:R30_W];
			sum_s1  <= in_sum;
			ctl_s1  <= in_ctl;
			x_s2    <= x_s1;
			q0_s2   <= prod_b[63:32];
			sum_s2  <= sum_s1;
			ctl_s2  <= ctl_s1;
			term_s3 <= quo[TERM_W-1:0];
			sum_s3  <= ODD ? sum_s2 - term_ext : sum_s2 + term_ext;
			ctl_s3  <= ctl_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign out_valid = vld_s3;
	assign out_term  = term_s3;
	assign out_sum   = sum_s3;
	assign out_ctl   = ctl_s3;

endmodule
`default_nettype wire

@@ tb/exp_distance_kernel_weight_checker.sv @@
// Scoreboard that predicts and checks every kernel weight leaving the block.
`timescale 1ns / 1ps
module exp_distance_kernel_weight_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [edk_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [edk_pkg::REG_W-1:0]     cfg_wdata,
	output int          fail_count,
	output int          pending
);
	import edk_pkg::*;

	localparam int unsigned GRID_X = 256;
	localparam int unsigned GRID_Y = 256;

	logic [REG_W-1:0] width_q, height_q, decay_q;
	logic [WEIGHT_W-1:0] weight_q[$];

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic [WEIGHT_W-1:0] kernel_weight(input logic [31:0] cells);
		logic [63:0] rx, ry, cx, cy, dx, dy, h, a, n, r30, term;
		logic signed [63:0] acc;
		rx = cells[7:0];
		ry = cells[15:8];
		cx = cells[23:16];
		cy = cells[31:24];
		if (rx >= GRID_X || cx >= GRID_X || ry >= GRID_Y || cy >= GRID_Y)
			return '0;
		dx = ((rx > cx) ? rx - cx : cx - rx) * width_q;
		dy = ((ry > cy) ? ry - cy : cy - ry) * height_q;
		h = int_sqrt(((dx * dx) >> 2) + ((dy * dy) >> 2));
		a = (64'd2 * h * decay_q) >> 16;
		if (a >= EXP_LIMIT)
			return '0;
		n = a / LN2_Q16;
		r30 = (a - n * LN2_Q16) << 14;
		term = 64'd1 << 30;
		acc = term;
		for (int k = 1; k <= TAYLOR_TERMS; k++) begin
			term = (term * r30) / (64'(k) << 30);
			if (k % 2 == 1)
				acc = acc - $signed(term);
			else
				acc = acc + $signed(term);
		end
		return WEIGHT_W'((64'(acc) + (64'd1 << (13 + n))) >> (14 + n));
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t: %s", $realtime, msg);
		fail_count++;
	endtask

	assign pending = weight_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CELL_WIDTH_RST;
			height_q <= CELL_HEIGHT_RST;
			decay_q  <= DECAY_SCALE_RST;
			weight_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CELL_WIDTH:  width_q  <= cfg_wdata;
					REG_CELL_HEIGHT: height_q <= cfg_wdata;
					REG_DECAY_SCALE: decay_q  <= cfg_wdata;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				weight_q.push_back(kernel_weight(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (weight_q.size() == 0) begin
					report_mismatch("weight beat with nothing expected");
				end else if (m_axis_tdata[16:0] !== weight_q[0]) begin
					report_mismatch($sformatf("weight mismatch, expected %0d got %0d",
						weight_q[0], m_axis_tdata[16:0]));
					void'(weight_q.pop_front());
				end else begin
					void'(weight_q.pop_front());
				end
			end
		end
	end
endmodule

@@ tb/exp_distance_kernel_weight_top_test.sv @@
// Stimulus, clocking and verdict for the kernel weight block.
`timescale 1ns / 1ps
module exp_distance_kernel_weight_top_test;
	import edk_pkg::*;

	// Index 3 is outside the register list and must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 150;
	localparam logic [REG_W-1:0] REG_MAX = 24'hFFFFFF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // row_x, row_y, col_x, col_y
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // weight, zero padding
	logic        cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0]     cfg_wdata = '0;
	int fail_count, pending;
	int quiet_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	exp_distance_kernel_weight_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	exp_distance_kernel_weight_checker scoreboard (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pending(pending)
	);

	// The receiver alternates between stretches of steady readiness, stretches of
	// random stalls of varying density and stretches of steady stalling.
	int rx_left = 0;
	int rx_mode = 0;
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_left = $urandom_range(1, 80);
			rx_mode = $urandom_range(0, 3);
		end
		rx_left--;
		case (rx_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 3) != 0);
			2: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default: m_axis_tready <= 1'b0;
		endcase
	end

	// The watchdog ends the run if neither channel moves a beat for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("exp_distance_kernel_weight_top verification failed");
			$finish;
		end
	end

	// Present one beat and hold it until the block takes it. The ready seen
	// just after the falling edge is the one the next rising edge uses.
	task automatic send_cells(input logic [7:0] rx, ry, cx, cy);
		logic ok;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {cy, cx, ry, rx};
		forever begin
			#1 ok = s_axis_tready;
			@(posedge clk);
			if (ok) break;
			@(negedge clk);
		end
	endtask

	task automatic pause_sender(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Registers change only once every expected weight has come back.
	task automatic drain();
		pause_sender(1);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic configure(input logic [REG_W-1:0] w, h, d);
		drain();
		write_reg(REG_CELL_WIDTH, w);
		write_reg(REG_CELL_HEIGHT, h);
		write_reg(REG_DECAY_SCALE, d);
	endtask

	// Random traffic in bursts. Most pairs lie close together so that the
	// weight is not simply zero; the rest span the whole index range.
	task automatic random_burst(input int count);
		logic [7:0] rx, ry, cx, cy;
		int burst;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			rx = 8'($urandom_range(0, 255));
			ry = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 2) != 0) begin
				cx = rx + 8'($urandom_range(0, 15)) - 8'd7;
				cy = ry + 8'($urandom_range(0, 15)) - 8'd7;
			end else begin
				cx = 8'($urandom_range(0, 255));
				cy = 8'($urandom_range(0, 255));
			end
			if (burst == 0) begin
				burst = $urandom_range(1, 40);
				if ($urandom_range(0, 1)) pause_sender($urandom_range(1, 12));
			end
			burst--;
			send_cells(rx, ry, cx, cy);
		end
	endtask

	task automatic directed_items();
		send_cells(8'd0, 8'd0, 8'd0, 8'd0);
		send_cells(8'd255, 8'd255, 8'd255, 8'd255);
		send_cells(8'd0, 8'd0, 8'd255, 8'd255);
		send_cells(8'd255, 8'd0, 8'd0, 8'd255);
		send_cells(8'd1, 8'd0, 8'd0, 8'd0);
		send_cells(8'd0, 8'd1, 8'd0, 8'd0);
		send_cells(8'd0, 8'd0, 8'd1, 8'd1);
		send_cells(8'd10, 8'd20, 8'd13, 8'd24);
		send_cells(8'd128, 8'd64, 8'd127, 8'd65);
		send_cells(8'd170, 8'd85, 8'd85, 8'd170);
		send_cells(8'd5, 8'd5, 8'd5, 8'd200);
		send_cells(8'd200, 8'd7, 8'd0, 8'd7);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset values first, then the extreme and special settings.
		directed_items();
		random_burst(200);

		configure(24'd1, 24'd1, REG_MAX);
		directed_items();
		random_burst(180);

		// Zero decay makes every weight exactly one.
		configure(REG_MAX, REG_MAX, 24'd0);
		directed_items();
		random_burst(120);

		// Zero cell size counts as no distance along that axis.
		configure(24'd0, 24'd65536, 24'd8192);
		random_burst(120);
		configure(24'd32768, 24'd0, 24'd8192);
		random_burst(120);

		// A write to the spare index must leave the registers alone.
		drain();
		write_reg(REG_SPARE, REG_MAX);
		random_burst(60);

		configure(REG_MAX, REG_MAX, REG_MAX);
		directed_items();
		random_burst(60);

		repeat (4) begin
			configure(24'($urandom_range(1, 24'h3FFFF)), 24'($urandom_range(1, 24'h3FFFF)),
				24'($urandom_range(0, 24'h1FFFF)));
			random_burst(130);
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("exp_distance_kernel_weight_top verification clean");
		else
			$display("exp_distance_kernel_weight_top verification failed");
		$finish;
	end
endmodule

@@ filelist.f @@
rtl/edk_pkg.sv
rtl/edk_isqrt.sv
rtl/edk_term.sv
rtl/exp_distance_kernel_weight_top.sv
tb/exp_distance_kernel_weight_checker.sv
tb/exp_distance_kernel_weight_top_test.sv
